// ----- sv/scl2x_pkg.sv -----
// Shared constants, register indexes, types and the Scale2x pixel rules
// for the Scale2x upscaler. No dependencies.
package scl2x_pkg;

  localparam int MAX_STRIDE_DEF = 512;
  localparam int PIXEL_BITS_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int BLOCK_W    = 4 * DATA_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int ROW_W      = 11;
  localparam int MIN_STRIDE = 3;

  localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_STRIDE   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_COLUMN  = 2'd3;

  localparam logic [8:0] RST_ACTIVE_WIDTH  = 9'd320;
  localparam logic [9:0] RST_ACTIVE_HEIGHT = 10'd224;
  localparam logic [9:0] RST_LINE_STRIDE   = 10'd336;
  localparam logic [8:0] RST_FIRST_COLUMN  = 9'd8;

  typedef struct packed {
    logic emit;
    logic last;
    logic wrap;
  } pos_flags_t;

  // Returns {E3, E2, E1, E0}, E0 in the lowest bits.
  function automatic logic [BLOCK_W-1:0] scale2x_block(
    input logic [DATA_W-1:0] b,
    input logic [DATA_W-1:0] d,
    input logic [DATA_W-1:0] e,
    input logic [DATA_W-1:0] f,
    input logic [DATA_W-1:0] h
  );
    logic [DATA_W-1:0] e0;
    logic [DATA_W-1:0] e1;
    logic [DATA_W-1:0] e2;
    logic [DATA_W-1:0] e3;
    e0 = (d == b && b != f && d != h) ? d : e;
    e1 = (b == f && b != d && f != h) ? f : e;
    e2 = (d == h && d != b && h != f) ? d : e;
    e3 = (h == f && d != h && b != f) ? f : e;
    return {e3, e2, e1, e0};
  endfunction

endpackage

// ----- sv/scl2x_ram.sv -----
// Line memory: one write port and one registered read port, read-before-write.
// Depends on nothing.
module scl2x_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/scl2x_addr_gen.sv -----
// Configuration registers, column and row counters, and per-pixel address
// and block flags. Depends on scl2x_pkg.
module scl2x_addr_gen #(
  parameter int MAX_STRIDE = scl2x_pkg::MAX_STRIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [scl2x_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [scl2x_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                step,
  input  logic                                frame_start,
  output logic [$clog2(MAX_STRIDE)-1:0]       col_addr,
  output logic [$clog2(MAX_STRIDE)-1:0]       f_addr,
  output scl2x_pkg::pos_flags_t               flags
);

  localparam int ADDR_W = $clog2(MAX_STRIDE);
  localparam int ROW_W  = scl2x_pkg::ROW_W;

  logic [8:0]        active_width_r;
  logic [9:0]        active_height_r;
  logic [9:0]        line_stride_r;
  logic [8:0]        first_column_r;
  logic [ADDR_W-1:0] col_r;
  logic [ROW_W-1:0]  row_r;
  logic [ADDR_W-1:0] col_nxt;
  logic [ROW_W-1:0]  row_nxt;

  logic [31:0]      stride;
  logic [31:0]      last_idx;
  logic [31:0]      col_cur;
  logic [31:0]      col_eff;
  logic [31:0]      active_end;
  logic [31:0]      last_blk;
  logic [31:0]      bottom_row;
  logic [ROW_W-1:0] row_cur;

  always_comb begin
    stride = 32'(line_stride_r);
    if (stride < 32'(scl2x_pkg::MIN_STRIDE)) begin
      stride = 32'(scl2x_pkg::MIN_STRIDE);
    end else if (stride > 32'(MAX_STRIDE)) begin
      stride = 32'(MAX_STRIDE);
    end
    last_idx = stride - 32'd1;

    col_cur = frame_start ? 32'd0 : 32'(col_r);
    row_cur = frame_start ? '0 : row_r;
    col_eff = (col_cur > last_idx) ? last_idx : col_cur;

    active_end = 32'(first_column_r) + 32'(active_width_r);
    last_blk   = (active_end - 32'd1 > last_idx) ? last_idx : active_end - 32'd1;
    bottom_row = 32'(active_height_r) + 32'd1;

    flags.emit = (32'(row_cur) >= 32'd2) && (32'(row_cur) <= bottom_row) &&
                 (active_width_r != '0) && (col_eff >= 32'(first_column_r)) &&
                 (col_eff < active_end);
    flags.last = (32'(row_cur) == bottom_row) && (col_eff == last_blk);
    flags.wrap = (col_eff == last_idx);

    col_addr = col_eff[ADDR_W-1:0];
    f_addr   = flags.wrap ? '0 : col_eff[ADDR_W-1:0] + ADDR_W'(1);

    if (flags.wrap) begin
      col_nxt = '0;
      row_nxt = (row_cur != scl2x_pkg::ROW_MAX) ? row_cur + ROW_W'(1) : row_cur;
    end else begin
      col_nxt = col_eff[ADDR_W-1:0] + ADDR_W'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= scl2x_pkg::RST_ACTIVE_WIDTH;
      active_height_r <= scl2x_pkg::RST_ACTIVE_HEIGHT;
      line_stride_r   <= scl2x_pkg::RST_LINE_STRIDE;
      first_column_r  <= scl2x_pkg::RST_FIRST_COLUMN;
      col_r           <= '0;
      row_r           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          scl2x_pkg::REG_ACTIVE_WIDTH:  active_width_r  <= cfg_wdata[8:0];
          scl2x_pkg::REG_ACTIVE_HEIGHT: active_height_r <= cfg_wdata;
          scl2x_pkg::REG_LINE_STRIDE:   line_stride_r   <= cfg_wdata;
          scl2x_pkg::REG_FIRST_COLUMN:  first_column_r  <= cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (step) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

// ----- sv/scale2x_pixel_upscaler_unit.sv -----
// Top level of the Scale2x upscaler: line memories, window, rules stage and
// output register. Depends on scl2x_pkg, scl2x_ram and scl2x_addr_gen.
//
// Source pixels enter in raster order on the in_ channel, one beat per pixel;
// in_tuser high marks the first pixel of the border line above the frame.
// For every active centre pixel the out_ channel delivers one beat holding
// the 2x2 block E0..E3; out_tlast marks the last block of the frame.
// The cfg_ port writes active width, active height, line stride and first
// column; write it only while no beat is in flight.
// A block is built from the registered line-memory reads and leaves through
// the output register once the beat of the pixel below its centre is taken.
// Throughput: one pixel per cycle while the output is not stalled; a
// write-back of the upper line is forwarded to a same-cycle read of that column.
// Reset clears counters, pipeline and output valid; the line memories keep
// their contents and fill again during the first two lines of a frame.
// When the receiver holds out_tready low the output beat holds, the stage
// behind it holds once it carries a block, and in_tready drops then.
module scale2x_pixel_upscaler_unit #(
  parameter int MAX_STRIDE = scl2x_pkg::MAX_STRIDE_DEF,
  parameter int PIXEL_BITS = scl2x_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [scl2x_pkg::DATA_W-1:0]         in_tdata,   // pixel_in
  input  logic                                 in_tuser,   // frame_start
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // top_left, top_right, bottom_left, bottom_right
  output logic [scl2x_pkg::BLOCK_W-1:0]        out_tdata,
  output logic                                 out_tlast,  // frame_last
  input  logic                                 cfg_we,
  input  logic [scl2x_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [scl2x_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ADDR_W = $clog2(MAX_STRIDE);
  localparam int DATA_W = scl2x_pkg::DATA_W;

  logic                  accept;
  logic                  s1_go;
  logic [ADDR_W-1:0]     col_addr;
  logic [ADDR_W-1:0]     f_addr;
  scl2x_pkg::pos_flags_t flags;

  logic [PIXEL_BITS-1:0] h_in;
  logic [PIXEL_BITS-1:0] e_cur;
  logic [PIXEL_BITS-1:0] f_cur;
  logic [PIXEL_BITS-1:0] up_rdata;
  logic [PIXEL_BITS-1:0] b_cur;

  logic                  s1_valid_r;
  logic [ADDR_W-1:0]     s1_col_r;
  logic [PIXEL_BITS-1:0] s1_h_r;
  logic                  s1_emit_r;
  logic                  s1_last_r;
  logic                  fwd_r;
  logic [PIXEL_BITS-1:0] fwd_pix_r;
  logic [PIXEL_BITS-1:0] win_d_r;
  logic                  out_valid_r;
  logic [scl2x_pkg::BLOCK_W-1:0] out_data_r;
  logic                  out_last_r;
  logic [scl2x_pkg::BLOCK_W-1:0] block;

  assign h_in   = in_tdata[PIXEL_BITS-1:0];
  assign s1_go  = s1_valid_r && (!s1_emit_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign accept = in_tvalid && in_tready;

  scl2x_addr_gen #(
    .MAX_STRIDE (MAX_STRIDE)
  ) u_addr_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .step        (accept),
    .frame_start (in_tuser),
    .col_addr    (col_addr),
    .f_addr      (f_addr),
    .flags       (flags)
  );

  scl2x_ram #(
    .DEPTH (MAX_STRIDE),
    .WIDTH (PIXEL_BITS)
  ) u_centre_e (
    .clk   (clk),
    .we    (accept),
    .waddr (col_addr),
    .wdata (h_in),
    .re    (accept),
    .raddr (col_addr),
    .rdata (e_cur)
  );

  scl2x_ram #(
    .DEPTH (MAX_STRIDE),
    .WIDTH (PIXEL_BITS)
  ) u_centre_f (
    .clk   (clk),
    .we    (accept),
    .waddr (col_addr),
    .wdata (h_in),
    .re    (accept),
    .raddr (f_addr),
    .rdata (f_cur)
  );

  scl2x_ram #(
    .DEPTH (MAX_STRIDE),
    .WIDTH (PIXEL_BITS)
  ) u_upper (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata (e_cur),
    .re    (accept),
    .raddr (col_addr),
    .rdata (up_rdata)
  );

  assign b_cur = fwd_r ? fwd_pix_r : up_rdata;

  assign block = scl2x_pkg::scale2x_block(DATA_W'(b_cur), DATA_W'(win_d_r),
                                          DATA_W'(e_cur), DATA_W'(f_cur),
                                          DATA_W'(s1_h_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
      win_d_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        win_d_r <= e_cur;
      end
      if (accept) begin
        fwd_r <= s1_go && (s1_col_r == col_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= col_addr;
      s1_h_r    <= h_in;
      s1_emit_r <= flags.emit;
      s1_last_r <= flags.last;
      fwd_pix_r <= e_cur;
    end
    if (s1_go && s1_emit_r) begin
      out_data_r <= block;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- sv/scl2x_checker.sv -----
// Port-level checks for the Scale2x upscaler and the bind that attaches them.
// Depends on scl2x_pkg and scale2x_pixel_upscaler_unit.
module scl2x_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [scl2x_pkg::BLOCK_W-1:0] out_tdata,
  input logic                          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("block without a source beat two cycles earlier");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind scale2x_pixel_upscaler_unit scl2x_checker u_scl2x_checker (.*);
